// ===== hw/rtl/iihmc_pkg.sv =====
// shared types, codes and constants of the iron idle heat mode controller
package iihmc_pkg;

    localparam int unsigned TEMP_W     = 10;
    localparam int unsigned DUTY_W     = 16;
    localparam int unsigned SECONDS_W  = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DELAY_MS_W = 26;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [DELAY_MS_W-1:0] MS_PER_SECOND  = DELAY_MS_W'(1000);
    localparam logic [TIME_W-1:0]     TIP_ABSENT_MS  = TIME_W'(2000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETBACK_TEMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETBACK_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STANDBY_DELAY = 3'd4;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_SETBACK = 2'd1,
        MODE_STANDBY = 2'd2,
        MODE_ERROR   = 2'd3
    } mode_t;

    // code three is unused and behaves as an evaluation
    typedef enum logic [1:0] {
        OP_EVAL   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_ERROR  = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    // live configuration, delays already scaled to milliseconds
    typedef struct packed {
        logic [TEMP_W-1:0]     target_temp;
        logic [TEMP_W-1:0]     setback_temp;
        logic [DUTY_W-1:0]     idle_thresh;
        logic [DELAY_MS_W-1:0] setback_ms;
        logic [DELAY_MS_W-1:0] standby_ms;
    } cfg_t;

    typedef struct packed {
        op_t               operation;
        logic [TIME_W-1:0] now_ms;
        logic              holder_open;
        logic              tip_present;
        logic [DUTY_W-1:0] duty_ch0;
        logic [DUTY_W-1:0] duty_ch1;
    } item_t;

    typedef struct packed {
        mode_t             mode;
        logic [TEMP_W-1:0] heat_target;
    } result_t;

endpackage

// ===== hw/rtl/iron_idle_heat_mode_controller.sv =====
// top level: input register, evaluation, result register and configuration
//
//  channel  | handshake                  | beat contents
//  ---------+----------------------------+----------------------------------------------
//  in       | in_valid / in_stall        | operation, now_ms, holder_open, tip_present,
//           |                            | duty_ch0, duty_ch1
//  out      | out_valid / out_stall      | mode, heat_target
//  config   | cfg_write                  | cfg_index, cfg_data
//
//  one beat per cycle sustained while out_stall is low; a result follows its input beat
//  through the input register, then evaluation into the result register
//  reset clears mode to normal, all timers and the target to zero, config to zero
//  out_stall holds the result register and, once it is full, the input register;
//  in_stall rises only when the input register holds a beat that cannot move
module iron_idle_heat_mode_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           operation,
    input  logic [iihmc_pkg::TIME_W-1:0]         now_ms,
    input  logic                                 holder_open,
    input  logic                                 tip_present,
    input  logic [iihmc_pkg::DUTY_W-1:0]         duty_ch0,
    input  logic [iihmc_pkg::DUTY_W-1:0]         duty_ch1,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           mode,
    output logic [iihmc_pkg::TEMP_W-1:0]         heat_target,
    input  logic                                 cfg_write,
    input  logic [iihmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iihmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import iihmc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    item_t   item_next;
    logic    in_valid_reg, in_valid_next;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;
    logic    step;
    logic    in_take;

    // result register frees up when empty or taken this cycle
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    assign item_next.operation   = op_t'(operation);
    assign item_next.now_ms      = now_ms;
    assign item_next.holder_open = holder_open;
    assign item_next.tip_present = tip_present;
    assign item_next.duty_ch0    = duty_ch0;
    assign item_next.duty_ch1    = duty_ch1;

    assign in_valid_next  = in_take || (in_valid_reg && !step);
    assign out_valid_next = step || (out_valid_reg && out_stall);

    iihmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iihmc_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_next;
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode        = out_reg.mode;
    assign heat_target = out_reg.heat_target;

    // a beat is never evaluated into a full, stalled result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !step)
        else $error("result overwritten while stalled");

    // every evaluated beat shows up as a result next cycle
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("evaluated beat lost");

    // input side only stalls while holding a beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");

endmodule

// ===== hw/rtl/iihmc_cfg.sv =====
// configuration register file, delays converted to milliseconds on write
module iihmc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [iihmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iihmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output iihmc_pkg::cfg_t                      cfg
);
    import iihmc_pkg::*;

    cfg_t                  cfg_reg;
    cfg_t                  cfg_next;
    logic [DELAY_MS_W-1:0] delay_ms;

    // seconds to milliseconds, one small constant multiply
    assign delay_ms = DELAY_MS_W'(cfg_data[SECONDS_W-1:0]) * MS_PER_SECOND;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_TEMP:   cfg_next.target_temp  = cfg_data[TEMP_W-1:0];
                REG_SETBACK_TEMP:  cfg_next.setback_temp = cfg_data[TEMP_W-1:0];
                REG_IDLE_THRESH:   cfg_next.idle_thresh  = cfg_data[DUTY_W-1:0];
                REG_SETBACK_DELAY: cfg_next.setback_ms   = delay_ms;
                REG_STANDBY_DELAY: cfg_next.standby_ms   = delay_ms;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/iihmc_eval.sv =====
// mode state registers and the single-pass evaluation of one beat
module iihmc_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  iihmc_pkg::item_t   item,
    input  iihmc_pkg::cfg_t    cfg,
    output iihmc_pkg::result_t res
);
    import iihmc_pkg::*;

    mode_t             mode_reg, mode_next;
    mode_t             last_eval_reg, last_eval_next;
    logic              last_holder_reg, last_holder_next;
    logic [TIME_W-1:0] idle_reg, idle_next;
    logic [TIME_W-1:0] tip_seen_reg, tip_seen_next;
    logic              armed_reg, armed_next;
    logic [TEMP_W-1:0] target_reg, target_next;

    logic              in_use;
    logic [TIME_W-1:0] idle_age;
    logic [TIME_W-1:0] tip_age;
    logic              setback_due;
    logic              standby_due;
    logic              is_eval;

    // idle refresh and elapsed times, all modulo 2^32
    assign in_use   = item.holder_open &&
                      (item.duty_ch0 >= cfg.idle_thresh || item.duty_ch1 >= cfg.idle_thresh);
    assign idle_age = item.now_ms - (in_use ? item.now_ms : idle_reg);
    assign tip_age  = item.now_ms - tip_seen_reg;
    assign is_eval  = (item.operation == OP_EVAL) || (item.operation == OP_SPARE);

    assign setback_due = (cfg.setback_ms != '0) && (mode_reg == MODE_NORMAL) &&
                         (idle_age >= TIME_W'(cfg.setback_ms));
    assign standby_due = (cfg.standby_ms != '0) &&
                         (mode_reg == MODE_NORMAL || mode_reg == MODE_SETBACK) &&
                         (idle_age >= TIME_W'(cfg.standby_ms));

    // next state for one beat
    always_comb
    begin
        mode_next        = mode_reg;
        last_eval_next   = last_eval_reg;
        last_holder_next = last_holder_reg;
        idle_next        = idle_reg;
        tip_seen_next    = tip_seen_reg;
        armed_next       = armed_reg;
        target_next      = target_reg;

        unique case (item.operation)
            OP_TOGGLE:
            begin
                idle_next = item.now_ms;
                mode_next = (mode_reg == MODE_NORMAL) ? MODE_STANDBY : MODE_NORMAL;
            end
            OP_ERROR:
            begin
                mode_next = MODE_ERROR;
            end
            OP_EVAL, OP_SPARE:
            begin
                if (in_use)
                begin
                    idle_next = item.now_ms;
                end
                if (item.tip_present)
                begin
                    tip_seen_next = item.now_ms;
                    armed_next    = 1'b1;
                end

                // mode decision
                if (mode_reg != MODE_ERROR)
                begin
                    if (item.tip_present)
                    begin
                        priority if (setback_due)
                        begin
                            mode_next = MODE_SETBACK;
                        end
                        else if (standby_due)
                        begin
                            mode_next = MODE_STANDBY;
                        end
                        else
                        begin
                            mode_next = mode_reg;
                        end
                        if (item.holder_open && !last_holder_reg)
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    else
                    begin
                        idle_next = item.now_ms;
                    end
                end
                else if (!item.tip_present && armed_reg && tip_age >= TIP_ABSENT_MS)
                begin
                    mode_next = MODE_STANDBY;
                end

                // target follows a mode change
                if (mode_next != last_eval_reg)
                begin
                    unique case (mode_next)
                        MODE_NORMAL:
                        begin
                            idle_next   = item.now_ms;
                            target_next = cfg.target_temp;
                        end
                        MODE_SETBACK:
                        begin
                            if (cfg.setback_temp < target_reg)
                            begin
                                target_next = cfg.setback_temp;
                            end
                        end
                        MODE_STANDBY, MODE_ERROR:
                        begin
                            target_next = '0;
                        end
                    endcase
                end

                last_holder_next = item.holder_open;
                last_eval_next   = mode_next;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NORMAL;
            last_eval_reg   <= MODE_NORMAL;
            last_holder_reg <= 1'b0;
            idle_reg        <= '0;
            tip_seen_reg    <= '0;
            armed_reg       <= 1'b0;
            target_reg      <= '0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            last_eval_reg   <= last_eval_next;
            last_holder_reg <= last_holder_next;
            idle_reg        <= idle_next;
            tip_seen_reg    <= tip_seen_next;
            armed_reg       <= armed_next;
            target_reg      <= target_next;
        end
    end

    assign res.mode        = mode_next;
    assign res.heat_target = target_next;

    // an error report always lands in error mode
    a_error_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.operation == OP_ERROR) |=> (mode_reg == MODE_ERROR))
        else $error("error report did not enter error mode");

    // a toggle restarts the idle timer
    a_toggle_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.operation == OP_TOGGLE) |=> (idle_reg == $past(item.now_ms)))
        else $error("toggle did not restart idle timer");

    // heater off once an evaluation settles in standby or error
    a_off_target: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_eval && (mode_next == MODE_STANDBY || mode_next == MODE_ERROR))
        |=> (target_reg == '0))
        else $error("heat target not zero in standby or error");

    // an evaluation records the mode it settled on
    a_last_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_eval) |=> (last_eval_reg == mode_reg))
        else $error("evaluated mode not recorded");

endmodule
